// ===== src/i2c_eeprom_master_core_defines.svh =====
// ----------------------------------------------------------------------------
// I2C EEPROM master assertion macros
// Shared concurrent assertion wrappers clocked on clk.
// ----------------------------------------------------------------------------
`ifndef I2C_EEPROM_MASTER_CORE_DEFINES_SVH
`define I2C_EEPROM_MASTER_CORE_DEFINES_SVH

// Checked outside of reset.
`define I2CEE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked in every cycle, reset included.
`define I2CEE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/i2cee_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C EEPROM master package
// Command codes, configuration register indexes and fixed field widths.
// ----------------------------------------------------------------------------
package i2cee_pkg;

  localparam int ADDR_W = 8;
  localparam int DATA_W = 8;
  localparam int DEV_W  = 7;
  localparam int CFG_W  = 16;
  localparam int IDX_W  = 2;

  typedef logic [1:0] op_t;
  localparam op_t OP_NONE     = 2'd0;
  localparam op_t OP_WRITE    = 2'd1;
  localparam op_t OP_RAND_RD  = 2'd2;
  localparam op_t OP_CUR_RD   = 2'd3;

  typedef logic [IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_DEVICE_ADDRESS = 2'd0;
  localparam cfg_idx_t REG_HALF_PERIOD    = 2'd1;
  localparam cfg_idx_t REG_WRITE_RECOVERY = 2'd2;

  localparam logic [DEV_W-1:0] DEV_ADDR_RESET   = 7'd80;
  localparam logic [CFG_W-1:0] HALF_PERIOD_RESET = 16'd250;
  localparam logic [CFG_W-1:0] RECOVERY_RESET    = 16'd100;

  localparam logic RW_WRITE = 1'b0;
  localparam logic RW_READ  = 1'b1;

endpackage

// ===== src/i2c_eeprom_master_core.sv =====
// ----------------------------------------------------------------------------
// I2C EEPROM master core
// Tick-driven I2C master for byte write, random read and current read.
// ----------------------------------------------------------------------------
//
//  Channel  | Signals                                    | Direction
//  ---------+--------------------------------------------+----------
//  config   | cfg_write, cfg_index, cfg_data             | in
//  tick in  | in_valid/in_ready, operation, mem_address, | in
//           | write_data, sda_in                         |
//  pins out | out_valid/out_ready, scl, sda_release,     | out
//           | busy_res, read_valid, read_data            |
//
//  One tick is accepted per clock cycle; its pin levels appear in the result
//  register in the next cycle. The sequencer state is updated by a single level
//  of next-state logic, so back-to-back ticks run at full rate.
//  Reset returns the sequencer to idle and empties the result register.
//  A stalled result only blocks a new tick when it is not taken in that cycle.

`include "i2c_eeprom_master_core_defines.svh"

module i2c_eeprom_master_core #(
  parameter int TIMER_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [i2cee_pkg::IDX_W-1:0]    cfg_index,
  input  logic [i2cee_pkg::CFG_W-1:0]    cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     operation,
  input  logic [i2cee_pkg::ADDR_W-1:0]   mem_address,
  input  logic [i2cee_pkg::DATA_W-1:0]   write_data,
  input  logic                           sda_in,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           scl,
  output logic                           sda_release,
  output logic                           busy_res,
  output logic                           read_valid,
  output logic [i2cee_pkg::DATA_W-1:0]   read_data
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_START  = 4'd1;
  localparam logic [3:0] S_CTRLW  = 4'd2;
  localparam logic [3:0] S_ACK1   = 4'd3;
  localparam logic [3:0] S_ADDR   = 4'd4;
  localparam logic [3:0] S_ACK2   = 4'd5;
  localparam logic [3:0] S_DATA   = 4'd6;
  localparam logic [3:0] S_ACK3   = 4'd7;
  localparam logic [3:0] S_STOPW  = 4'd8;
  localparam logic [3:0] S_RECOV  = 4'd9;
  localparam logic [3:0] S_RSTART = 4'd10;
  localparam logic [3:0] S_CTRLR  = 4'd11;
  localparam logic [3:0] S_ACK4   = 4'd12;
  localparam logic [3:0] S_READ   = 4'd13;
  localparam logic [3:0] S_NACK   = 4'd14;
  localparam logic [3:0] S_STOPR  = 4'd15;

  localparam logic [32:0] TMAX = (33'd1 << TIMER_WIDTH) - 33'd1;

  // Configuration registers.
  logic [i2cee_pkg::DEV_W-1:0] device_address;
  logic [i2cee_pkg::CFG_W-1:0] half_period;
  logic [i2cee_pkg::CFG_W-1:0] write_recovery;

  // Sequencer state.
  logic [3:0]                   state, state_next;
  logic [1:0]                   phase, phase_next;
  logic [2:0]                   bit_idx, bit_idx_next;
  logic [TIMER_WIDTH-1:0]       tick_cnt, tick_cnt_next;
  logic [7:0]                   shift, shift_next;
  logic [7:0]                   addr_latch, addr_latch_next;
  logic [7:0]                   data_latch, data_latch_next;
  logic                         pend_read, pend_read_next;

  logic                         in_fire;
  logic [TIMER_WIDTH-1:0]       hp_clip, hp_eff, rec_clip;
  logic [32:0]                  hp_ext, rec_ext;

  logic                         scl_c, rel_c, busy_c, valid_c;
  logic [7:0]                   rdata_c;
  logic                         done, three_ph, sending, phase_end;
  logic [3:0]                   step;
  logic [TIMER_WIDTH:0]         tick_inc;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  // Timer registers saturate at the counter's range.
  assign hp_ext   = {17'd0, half_period};
  assign rec_ext  = {17'd0, write_recovery};
  assign hp_clip  = (hp_ext > TMAX) ? TMAX[TIMER_WIDTH-1:0] : hp_ext[TIMER_WIDTH-1:0];
  assign rec_clip = (rec_ext > TMAX) ? TMAX[TIMER_WIDTH-1:0] : rec_ext[TIMER_WIDTH-1:0];
  assign hp_eff   = (hp_clip == '0) ? TIMER_WIDTH'(1) : hp_clip;

  always_comb begin
    state_next      = state;
    phase_next      = phase;
    bit_idx_next    = bit_idx;
    tick_cnt_next   = tick_cnt;
    shift_next      = shift;
    addr_latch_next = addr_latch;
    data_latch_next = data_latch;
    pend_read_next  = pend_read;
    scl_c     = 1'b1;
    rel_c     = 1'b1;
    busy_c    = 1'b1;
    valid_c   = 1'b0;
    rdata_c   = '0;
    done      = 1'b0;
    step      = S_IDLE;
    three_ph  = 1'b0;
    sending   = 1'b0;
    phase_end = 1'b0;
    tick_inc  = '0;

    // A command on an idle tick starts on that same tick.
    if (state == S_IDLE && operation != i2cee_pkg::OP_NONE) begin
      addr_latch_next = mem_address;
      data_latch_next = write_data;
      pend_read_next  = (operation == i2cee_pkg::OP_RAND_RD);
      state_next      = (operation == i2cee_pkg::OP_CUR_RD) ? S_RSTART : S_START;
      phase_next      = '0;
      bit_idx_next    = '0;
      tick_cnt_next   = '0;
    end

    tick_inc = {1'b0, tick_cnt_next} + (TIMER_WIDTH+1)'(1);

    if (state_next == S_IDLE) begin
      busy_c = 1'b0;
    end else if (state_next == S_RECOV) begin
      if (rec_clip == '0 || tick_inc >= {1'b0, rec_clip}) begin
        done = 1'b1;
      end else begin
        tick_cnt_next = tick_inc[TIMER_WIDTH-1:0];
      end
    end else begin
      three_ph = (state_next == S_START) || (state_next == S_RSTART) ||
                 (state_next == S_STOPW) || (state_next == S_STOPR);
      sending  = (state_next == S_CTRLW) || (state_next == S_ADDR) ||
                 (state_next == S_DATA)  || (state_next == S_CTRLR);
      if (state_next == S_START || state_next == S_RSTART) begin
        scl_c = (phase_next < 2'd2);
        rel_c = (phase_next == 2'd0);
      end else if (state_next == S_STOPW || state_next == S_STOPR) begin
        scl_c = (phase_next != 2'd0);
        rel_c = (phase_next == 2'd2);
      end else begin
        scl_c = (phase_next != 2'd0);
        rel_c = sending ? shift_next[7] : 1'b1;
      end
      phase_end = (tick_inc >= {1'b0, hp_eff});
      if (phase_end) begin
        if (phase_next == 2'd1 && !three_ph) begin
          if (sending) begin
            shift_next = {shift_next[6:0], 1'b0};
          end else if (state_next == S_READ) begin
            shift_next = {shift_next[6:0], sda_in};
            if (bit_idx_next == 3'd7) begin
              valid_c = 1'b1;
              rdata_c = shift_next;
            end
          end
        end
        tick_cnt_next = '0;
        if ((three_ph && phase_next == 2'd2) || (!three_ph && phase_next == 2'd1)) begin
          phase_next = '0;
          // Byte steps run eight bits; ack, NACK, START and STOP run one.
          if ((sending || state_next == S_READ) && bit_idx_next != 3'd7) begin
            bit_idx_next = bit_idx_next + 3'd1;
          end else begin
            done = 1'b1;
          end
        end else begin
          phase_next = phase_next + 2'd1;
        end
      end else begin
        tick_cnt_next = tick_inc[TIMER_WIDTH-1:0];
      end
    end

    if (done) begin
      // A random read ends its dummy write after the address, then restarts.
      priority if (state_next == S_ACK2 && pend_read_next) begin
        step = S_STOPW;
      end else if (state_next == S_STOPW) begin
        if (pend_read_next) begin
          pend_read_next = 1'b0;
          step = S_RSTART;
        end else if (rec_clip != '0) begin
          step = S_RECOV;
        end else begin
          step = S_IDLE;
        end
      end else if (state_next == S_RECOV || state_next == S_STOPR) begin
        step = S_IDLE;
      end else begin
        step = state_next + 4'd1;
      end
      state_next    = step;
      phase_next    = '0;
      bit_idx_next  = '0;
      tick_cnt_next = '0;
      if (step == S_CTRLW) begin
        shift_next = {device_address, i2cee_pkg::RW_WRITE};
      end else if (step == S_CTRLR) begin
        shift_next = {device_address, i2cee_pkg::RW_READ};
      end else if (step == S_ADDR) begin
        shift_next = addr_latch_next;
      end else if (step == S_DATA) begin
        shift_next = data_latch_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= i2cee_pkg::DEV_ADDR_RESET;
      half_period    <= i2cee_pkg::HALF_PERIOD_RESET;
      write_recovery <= i2cee_pkg::RECOVERY_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        i2cee_pkg::REG_DEVICE_ADDRESS: device_address <= cfg_data[i2cee_pkg::DEV_W-1:0];
        i2cee_pkg::REG_HALF_PERIOD:    half_period    <= cfg_data;
        i2cee_pkg::REG_WRITE_RECOVERY: write_recovery <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      phase      <= '0;
      bit_idx    <= '0;
      tick_cnt   <= '0;
      shift      <= '0;
      addr_latch <= '0;
      data_latch <= '0;
      pend_read  <= 1'b0;
    end else if (in_fire) begin
      state      <= state_next;
      phase      <= phase_next;
      bit_idx    <= bit_idx_next;
      tick_cnt   <= tick_cnt_next;
      shift      <= shift_next;
      addr_latch <= addr_latch_next;
      data_latch <= data_latch_next;
      pend_read  <= pend_read_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      scl         <= scl_c;
      sda_release <= rel_c;
      busy_res    <= busy_c;
      read_valid  <= valid_c;
      read_data   <= rdata_c;
    end
  end

  `I2CEE_ASSERT(a_pending_only_busy, (state == S_IDLE) |-> !pend_read,
                "pending read flag set while idle")
  `I2CEE_ASSERT(a_phase_range,
                (state != S_START && state != S_RSTART &&
                 state != S_STOPW && state != S_STOPR) |-> (phase <= 2'd1),
                "third bit phase in a two-phase step")
  `I2CEE_ASSERT(a_read_in_high_phase,
                (out_valid && read_valid) |-> (busy_res && sda_release && scl),
                "read byte reported outside a released SCL-high phase")
  `I2CEE_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid,
                       "result register not empty after reset")

endmodule
